// File: hdl/hmp_pkg.sv
`timescale 1ns / 1ps

package hmp_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int WORD_BYTES  = 4;
    localparam int BLOCK_WORDS = BLOCK_BYTES / WORD_BYTES;
    localparam int LEN_OFFSET  = 56;

    localparam int FILL_W  = $clog2(BLOCK_BYTES);
    localparam int MARK_W  = FILL_W + 1;
    localparam int WORD_W  = $clog2(BLOCK_WORDS);
    localparam int LANE_W  = $clog2(WORD_BYTES);
    localparam int COUNT_W = 61;
    localparam int ADDR_W  = 2;

    localparam logic [7:0]        PAD_MARK      = 8'h80;
    localparam logic [ADDR_W-1:0] REG_HASH_MODE = '0;
    localparam logic              MODE_MD5      = 1'b0;
    localparam logic              MODE_SHA256   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PREP = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic              with_len;
        logic              zero;
        logic              mode;
    } t_fmt_ctl;

endpackage

// File: hdl/hmp_block_mem.sv
`timescale 1ns / 1ps

module hmp_block_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [hmp_pkg::WORD_W-1:0]  i_waddr,
    input  logic [hmp_pkg::LANE_W-1:0]  i_wlane,
    input  logic [7:0]                  i_wdata,
    input  logic [hmp_pkg::WORD_W-1:0]  i_raddr,
    output logic [31:0]                 o_rdata
);

    logic [31:0] r_mem [hmp_pkg::BLOCK_WORDS];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < hmp_pkg::WORD_BYTES; l++) begin
            if (i_we && (i_wlane == hmp_pkg::LANE_W'(l))) begin
                r_mem[i_waddr][8*l +: 8] <= i_wdata;
            end
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/hmp_word_fmt.sv
`timescale 1ns / 1ps

module hmp_word_fmt (
    input  hmp_pkg::t_fmt_ctl              i_ctl,
    input  logic [hmp_pkg::WORD_W-1:0]     i_word,
    input  logic [31:0]                    i_rdata,
    input  logic [hmp_pkg::COUNT_W-1:0]    i_count,
    output logic [31:0]                    o_word
);

    logic [63:0] bit_len;

    assign bit_len = {i_count, 3'b000};

    always_comb begin
        logic [hmp_pkg::FILL_W-1:0] pos;
        logic [2:0]                 k;
        logic [2:0]                 sel;
        o_word = '0;
        for (int j = 0; j < hmp_pkg::WORD_BYTES; j++) begin
            pos = {i_word, hmp_pkg::LANE_W'(j)};
            k   = pos[2:0];
            sel = (i_ctl.mode == hmp_pkg::MODE_SHA256) ? ~k : k;
            if (i_ctl.with_len && (pos >= hmp_pkg::FILL_W'(hmp_pkg::LEN_OFFSET))) begin
                o_word[8*j +: 8] = bit_len[{sel, 3'b000} +: 8];
            end else if (i_ctl.zero) begin
                o_word[8*j +: 8] = 8'h00;
            end else if ({1'b0, pos} < i_ctl.mark) begin
                o_word[8*j +: 8] = i_rdata[8*j +: 8];
            end else if ({1'b0, pos} == i_ctl.mark) begin
                o_word[8*j +: 8] = hmp_pkg::PAD_MARK;
            end else begin
                o_word[8*j +: 8] = 8'h00;
            end
        end
    end

endmodule

// File: hdl/hash_message_padder_top.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake                  | Payload
// input   | in        | i_in_valid / o_in_stall    | i_data_byte, i_has_byte, i_end_of_message
// output  | out       | o_out_valid / i_out_stall  | o_block_word, o_word_index, o_block_end,
//         |           |                            | o_message_end
// config  | in        | psel, penable, pwrite      | paddr, pwdata, prdata
//
// While no block is being read out, bytes stream at one per cycle.
// A block readout primes the memory read port in a prepare state and then emits sixteen words,
// holding each while the output stalls; a trailing padding block adds sixteen more words.
// The input stalls for the whole readout, since the block memory has one read port.
// Reset is synchronous and active low; it clears the fill and length counts and hash_mode.

module hash_message_padder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_has_byte,
    input  logic                        i_end_of_message,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [31:0]                 o_block_word,
    output logic [3:0]                  o_word_index,
    output logic                        o_block_end,
    output logic                        o_message_end,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hmp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    hmp_pkg::t_state                  r_state, n_state;
    logic [hmp_pkg::FILL_W-1:0]       r_fill, n_fill;
    logic [hmp_pkg::COUNT_W-1:0]      r_count, n_count;
    logic [hmp_pkg::WORD_W-1:0]       r_word, n_word;
    logic [hmp_pkg::MARK_W-1:0]       r_mark, n_mark;
    logic                             r_with_len, n_with_len;
    logic                             r_zero, n_zero;
    logic                             r_pend_eom, n_pend_eom;
    logic                             r_mode;
    logic                             r_out_valid, n_out_valid;
    logic [31:0]                      r_out_word;
    logic [3:0]                       r_out_index;
    logic                             r_out_bend;
    logic                             r_out_mend;

    logic                             in_xfer;
    logic                             out_free;
    logic                             load_word;
    logic                             mem_we;
    logic [hmp_pkg::MARK_W-1:0]       fill_inc;
    logic [31:0]                      rdata;
    logic [31:0]                      fmt_word;
    hmp_pkg::t_fmt_ctl                fmt_ctl;

    assign in_xfer  = i_in_valid && (r_state == hmp_pkg::ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign load_word = (r_state == hmp_pkg::ST_EMIT) && out_free;
    assign mem_we   = in_xfer && i_has_byte;
    assign fill_inc = {1'b0, r_fill} + hmp_pkg::MARK_W'(i_has_byte);

    assign fmt_ctl.mark     = r_mark;
    assign fmt_ctl.with_len = r_with_len;
    assign fmt_ctl.zero     = r_zero;
    assign fmt_ctl.mode     = r_mode;

    hmp_block_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_fill[hmp_pkg::FILL_W-1:hmp_pkg::LANE_W]),
        .i_wlane (r_fill[hmp_pkg::LANE_W-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (n_word),
        .o_rdata (rdata)
    );

    hmp_word_fmt u_fmt (
        .i_ctl   (fmt_ctl),
        .i_word  (r_word),
        .i_rdata (rdata),
        .i_count (r_count),
        .o_word  (fmt_word)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_count     = r_count;
        n_word      = r_word;
        n_mark      = r_mark;
        n_with_len  = r_with_len;
        n_zero      = r_zero;
        n_pend_eom  = r_pend_eom;
        n_out_valid = r_out_valid;
        if (!r_out_valid || !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            hmp_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_fill  = fill_inc[hmp_pkg::FILL_W-1:0];
                    n_count = r_count + hmp_pkg::COUNT_W'(i_has_byte);
                    n_word  = '0;
                    if (fill_inc[hmp_pkg::MARK_W-1]) begin
                        n_mark     = fill_inc;
                        n_with_len = 1'b0;
                        n_zero     = 1'b0;
                        n_pend_eom = i_end_of_message;
                        n_state    = hmp_pkg::ST_PREP;
                    end else if (i_end_of_message) begin
                        n_mark     = fill_inc;
                        n_with_len = fill_inc < hmp_pkg::MARK_W'(hmp_pkg::LEN_OFFSET);
                        n_zero     = 1'b0;
                        n_pend_eom = 1'b0;
                        n_state    = hmp_pkg::ST_PREP;
                    end
                end
            end
            hmp_pkg::ST_PREP: begin
                n_state = hmp_pkg::ST_EMIT;
            end
            hmp_pkg::ST_EMIT: begin
                if (load_word) begin
                    n_out_valid = 1'b1;
                    n_word      = r_word + 1'b1;
                    if (r_word == hmp_pkg::WORD_W'(hmp_pkg::BLOCK_WORDS - 1)) begin
                        if (r_mark[hmp_pkg::MARK_W-1]) begin
                            if (r_pend_eom) begin
                                n_mark     = '0;
                                n_with_len = 1'b1;
                                n_pend_eom = 1'b0;
                            end else begin
                                n_state = hmp_pkg::ST_IDLE;
                            end
                        end else if (!r_with_len) begin
                            n_zero     = 1'b1;
                            n_with_len = 1'b1;
                        end else begin
                            n_fill  = '0;
                            n_count = '0;
                            n_state = hmp_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = hmp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hmp_pkg::ST_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_word      <= '0;
            r_mark      <= '0;
            r_with_len  <= 1'b0;
            r_zero      <= 1'b0;
            r_pend_eom  <= 1'b0;
            r_mode      <= hmp_pkg::MODE_MD5;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_word      <= n_word;
            r_mark      <= n_mark;
            r_with_len  <= n_with_len;
            r_zero      <= n_zero;
            r_pend_eom  <= n_pend_eom;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && (paddr == hmp_pkg::REG_HASH_MODE)) begin
                r_mode <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_word) begin
            r_out_word  <= fmt_word;
            r_out_index <= r_word;
            r_out_bend  <= (r_word == hmp_pkg::WORD_W'(hmp_pkg::BLOCK_WORDS - 1));
            r_out_mend  <= (r_word == hmp_pkg::WORD_W'(hmp_pkg::BLOCK_WORDS - 1))
                           && r_with_len;
        end
    end

    assign o_in_stall    = (r_state != hmp_pkg::ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_block_word  = r_out_word;
    assign o_word_index  = r_out_index;
    assign o_block_end   = r_out_bend;
    assign o_message_end = r_out_mend;
    assign prdata        = (paddr == hmp_pkg::REG_HASH_MODE) ? {31'b0, r_mode} : 32'b0;
    assign pready        = 1'b1;

endmodule

// File: hdl/hmp_checker.sv
`timescale 1ns / 1ps

module hmp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_stall,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_block_word,
    input  logic [3:0]  i_word_index,
    input  logic        i_block_end,
    input  logic        i_message_end
);

    // A stalled output transfer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_block_word)
            && $stable(i_word_index) && $stable(i_message_end))
        else $error("stalled output word changed");

    // The last word of a block carries the block end flag, and only it.
    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_block_end == (i_word_index == 4'd15)))
        else $error("block end flag does not match word index");

    // Message end only marks the final word of a block.
    a_msg_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_message_end |-> i_block_end)
        else $error("message end outside a block end");

    // While a block is part way out, no input byte can be taken.
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_word_index != 4'd15) |-> i_in_stall)
        else $error("input open during block readout");

endmodule

bind hash_message_padder_top hmp_checker u_hmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_stall    (o_in_stall),
    .i_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .i_block_word  (o_block_word),
    .i_word_index  (o_word_index),
    .i_block_end   (o_block_end),
    .i_message_end (o_message_end)
);
